>>> rtl/assert_macros.svh
// Assertion macros used by the buddy allocator controller.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BBA_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: check failed");

// Condition must never be seen outside reset.
`define BBA_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

>>> rtl/bba_pkg.sv
// Package of the buddy block allocator: field widths, status codes,
// datapath command and status types. No dependencies.
`default_nettype none
package bba_pkg;

  localparam int unsigned MODE_W = 1;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned STAT_W = 2;

  localparam logic [ADDR_W-1:0] BASE_AT_RESET = 32'h2000_1000;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_FIT   = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_ADDR = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_HALVE,
    OP_SCAN_RD,
    OP_SCAN_NEXT,
    OP_TAKE,
    OP_MARK_RD,
    OP_MARK_WR,
    OP_MARK_SKIP,
    OP_FAIL,
    OP_FREE_IDX,
    OP_FREE_RD,
    OP_FREE_CLR,
    OP_MERGE_RD,
    OP_MERGE_W1,
    OP_MERGE_W2,
    OP_PUBLISH
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STAT_W-1:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic size_bad;
    logic fits_half;
    logic scan_hit;
    logic scan_last;
    logic mark_done;
    logic mark_left;
    logic addr_ok;
    logic entry_zero;
    logic merge_ok;
    logic buddy_eq;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/bba_req_if.sv
// Request channel of the buddy allocator: mode, size and address.
// Depends on bba_pkg for field widths.
`default_nettype none
interface bba_req_if import bba_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output mode, output request_size, output address,
                  input ready);
  modport sink   (input valid, input mode, input request_size, input address,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/bba_rsp_if.sv
// Result channel of the buddy allocator: block address and status.
// Depends on bba_pkg for field widths.
`default_nettype none
interface bba_rsp_if import bba_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] block_address;
  logic [STAT_W-1:0] status;

  modport source (output valid, output block_address, output status, input ready);
  modport sink   (input valid, input block_address, input status, output ready);
endinterface
`default_nettype wire

>>> rtl/bba_cfg_if.sv
// Configuration write channel: heap base address write data.
// Depends on bba_pkg for the address width.
`default_nettype none
interface bba_cfg_if import bba_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/buddy_block_allocator_unit.sv
// Buddy allocator: after reset a clearing pass over all HEAP_BYTES/MIN_BLOCK
// entries (512 by default) fills the table; requests are held off until it ends.
// Allocate: size check, halvings, table scan, then split marking per level.
// Free: address check, table read and clear, then a buddy merge per level. One
// request at a time, the next taken the cycle after publish. Config: heap_base,
// reset 0x20001000. Depends on bba_pkg, channel interfaces, bba_ctrl, bba_datapath.
`default_nettype none
module buddy_block_allocator_unit import bba_pkg::*; #(
  parameter int unsigned HEAP_BYTES = 16384,
  parameter int unsigned MIN_BLOCK  = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bba_req_if.sink   in_bus,
  bba_rsp_if.source out_bus,
  bba_cfg_if.sink   cfg_bus
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;
  logic     out_valid;

  assign cfg_bus.ready = 1'b1;
  assign in_bus.ready  = in_ready;
  assign out_bus.valid = out_valid;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_bus.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_datapath #(
    .HEAP_BYTES(HEAP_BYTES),
    .MIN_BLOCK (MIN_BLOCK)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .req_mode  (in_bus.mode),
    .req_size  (in_bus.request_size),
    .req_addr  (in_bus.address),
    .cfg_we    (cfg_bus.valid),
    .cfg_data  (cfg_bus.data),
    .res_addr  (out_bus.block_address),
    .res_status(out_bus.status)
  );

endmodule
`default_nettype wire

>>> rtl/bba_datapath.sv
// Datapath of the buddy allocator: block table memory, walk and merge
// registers, result registers. Depends on bba_pkg; driven by bba_ctrl.
`default_nettype none
module bba_datapath import bba_pkg::*; #(
  parameter int unsigned HEAP_BYTES = 16384,
  parameter int unsigned MIN_BLOCK  = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat,
  input  wire logic [MODE_W-1:0] req_mode,
  input  wire logic [SIZE_W-1:0] req_size,
  input  wire logic [ADDR_W-1:0] req_addr,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_data,
  output logic [ADDR_W-1:0]      res_addr,
  output logic [STAT_W-1:0]      res_status
);

  localparam int unsigned UNITS   = HEAP_BYTES / MIN_BLOCK;
  localparam int unsigned AW      = $clog2(UNITS);
  localparam int unsigned EW      = $clog2(HEAP_BYTES) + 1;
  localparam int unsigned LOG_MIN = $clog2(MIN_BLOCK);
  localparam logic [EW-1:0]   HEAP_E  = EW'(HEAP_BYTES);
  localparam logic [EW-1:0]   MIN_E   = EW'(MIN_BLOCK);
  localparam logic [AW:0]     UNITS_U = (AW+1)'(UNITS);
  localparam logic [ADDR_W-1:0] LAST_OFS = ADDR_W'(HEAP_BYTES - MIN_BLOCK);

  // block table
  logic [EW-1:0] mem [UNITS];
  logic [EW-1:0] rd_data_r;

  logic [AW-1:0]     clr_r;
  logic [ADDR_W-1:0] base_r;
  logic [MODE_W-1:0] mode_r;
  logic [SIZE_W-1:0] size_r;
  logic [ADDR_W-1:0] addr_r;
  logic [EW-1:0]     blk_r,  blk_nxt;
  logic [AW:0]       unit_r, unit_nxt;
  logic [AW:0]       hu_r,   hu_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [STAT_W-1:0] pend_stat_r, pend_stat_nxt;
  logic [ADDR_W-1:0] res_addr_r;
  logic [STAT_W-1:0] res_stat_r;

  logic          we;
  logic [AW-1:0] wa;
  logic [EW-1:0] wd;
  logic          re;
  logic [AW-1:0] ra;

  logic [AW:0]       blk_units;
  logic [AW:0]       hu_mask;
  logic [AW:0]       mid;
  logic [AW:0]       buddy;
  logic              odd;
  logic [AW:0]       hi_idx, lo_idx;
  logic [ADDR_W-1:0] ofs;
  logic [EW-1:0]     cleared;
  logic [ADDR_W-1:0] unit_ofs;

  function automatic logic [ADDR_W-1:0] req_addr_diff(input logic [ADDR_W-1:0] a,
                                                      input logic [ADDR_W-1:0] b);
    req_addr_diff = a - b;
  endfunction

  // derived walk / merge values
  always_comb begin
    blk_units = (AW+1)'(blk_r >> LOG_MIN);
    hu_mask   = (hu_r << 1) - (AW+1)'(1);
    mid       = (unit_r & ~hu_mask) | hu_r;
    odd       = (unit_r & blk_units) != '0;
    buddy     = odd ? (unit_r - blk_units) : (unit_r + blk_units);
    hi_idx    = odd ? unit_r : buddy;
    lo_idx    = odd ? buddy : unit_r;
    ofs       = req_addr_diff(addr_r, base_r);
    cleared   = rd_data_r & ~EW'(1);
    unit_ofs  = ADDR_W'(unit_r) << LOG_MIN;
  end

  // status toward controller
  always_comb begin
    stat.clr_done   = clr_r == AW'(UNITS - 1);
    stat.is_free    = mode_r == MODE_FREE;
    stat.size_bad   = ({16'd0, size_r} < 32'(MIN_BLOCK)) ||
                      ({16'd0, size_r} > 32'(HEAP_BYTES));
    stat.fits_half  = (blk_r > MIN_E) && ({16'd0, size_r} <= 32'(blk_r >> 1));
    stat.scan_hit   = !rd_data_r[0] && (rd_data_r >= blk_r);
    stat.scan_last  = (unit_r + blk_units) >= UNITS_U;
    stat.mark_done  = hu_r >= UNITS_U;
    stat.mark_left  = (unit_r & hu_r) == '0;
    stat.addr_ok    = (addr_r >= base_r) && (ofs <= LAST_OFS);
    stat.entry_zero = cleared == '0;
    stat.merge_ok   = (blk_r < HEAP_E) && (blk_units != '0) &&
                      (odd ? (blk_units <= unit_r) : (buddy < UNITS_U));
    stat.buddy_eq   = rd_data_r == blk_r;
  end

  // memory port selection and register updates
  always_comb begin
    we            = 1'b0;
    wa            = unit_r[AW-1:0];
    wd            = '0;
    re            = 1'b0;
    ra            = unit_r[AW-1:0];
    blk_nxt       = blk_r;
    unit_nxt      = unit_r;
    hu_nxt        = hu_r;
    pend_addr_nxt = pend_addr_r;
    pend_stat_nxt = pend_stat_r;
    unique case (cmd.op)
      OP_CLEAR: begin
        we = 1'b1;
        wa = clr_r;
        wd = (clr_r == '0) ? HEAP_E : '0;
      end
      OP_LOAD: begin
        blk_nxt  = HEAP_E;
        unit_nxt = '0;
      end
      OP_HALVE:     blk_nxt = blk_r >> 1;
      OP_SCAN_RD:   re = 1'b1;
      OP_SCAN_NEXT: unit_nxt = unit_r + blk_units;
      OP_TAKE: begin
        we            = 1'b1;
        wd            = blk_r | EW'(1);
        hu_nxt        = blk_units;
        pend_addr_nxt = base_r + unit_ofs;
        pend_stat_nxt = ST_OK;
      end
      OP_MARK_RD: begin
        re = 1'b1;
        ra = mid[AW-1:0];
      end
      OP_MARK_WR: begin
        we     = !rd_data_r[0];
        wa     = mid[AW-1:0];
        wd     = EW'(hu_r) << LOG_MIN;
        hu_nxt = hu_r << 1;
      end
      OP_MARK_SKIP: hu_nxt = hu_r << 1;
      OP_FAIL: begin
        pend_addr_nxt = '0;
        pend_stat_nxt = cmd.code;
      end
      OP_FREE_IDX: unit_nxt = (AW+1)'(ofs >> LOG_MIN);
      OP_FREE_RD:  re = 1'b1;
      OP_FREE_CLR: begin
        we            = 1'b1;
        wd            = cleared;
        blk_nxt       = cleared;
        pend_addr_nxt = addr_r;
        pend_stat_nxt = ST_OK;
      end
      OP_MERGE_RD: begin
        re = 1'b1;
        ra = buddy[AW-1:0];
      end
      OP_MERGE_W1: begin
        we = 1'b1;
        wa = hi_idx[AW-1:0];
        wd = '0;
      end
      OP_MERGE_W2: begin
        we       = 1'b1;
        wa       = lo_idx[AW-1:0];
        wd       = blk_r << 1;
        blk_nxt  = blk_r << 1;
        unit_nxt = lo_idx;
      end
      OP_NONE, OP_PUBLISH: ;
      default: ;
    endcase
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_data_r <= mem[ra];
  end

  // control counters and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      base_r <= BASE_AT_RESET;
    end else begin
      if (cmd.op == OP_CLEAR) clr_r <= clr_r + AW'(1);
      if (cfg_we) base_r <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      mode_r <= req_mode;
      size_r <= req_size;
      addr_r <= req_addr;
    end
    if (cmd.op == OP_PUBLISH) begin
      res_addr_r <= pend_addr_r;
      res_stat_r <= pend_stat_r;
    end
    blk_r       <= blk_nxt;
    unit_r      <= unit_nxt;
    hu_r        <= hu_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_stat_r <= pend_stat_nxt;
  end

  assign res_addr   = res_addr_r;
  assign res_status = res_stat_r;

endmodule
`default_nettype wire

>>> rtl/bba_ctrl.sv
// Controller of the buddy allocator: one-hot sequencer for clear, allocate
// walk, split marking and free merge. Depends on bba_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module bba_ctrl import bba_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [17:0] {
    S_CLR  = 18'h00001,
    S_IDLE = 18'h00002,
    S_ACHK = 18'h00004,
    S_ALVL = 18'h00008,
    S_ARD  = 18'h00010,
    S_ATST = 18'h00020,
    S_MCHK = 18'h00040,
    S_MRD  = 18'h00080,
    S_MWR  = 18'h00100,
    S_FCHK = 18'h00200,
    S_FRD  = 18'h00400,
    S_FTST = 18'h00800,
    S_GCHK = 18'h01000,
    S_GRD  = 18'h02000,
    S_GTST = 18'h04000,
    S_GW1  = 18'h08000,
    S_GW2  = 18'h10000,
    S_FIN  = 18'h20000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd.op        = OP_NONE;
    cmd.code      = ST_OK;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      S_CLR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_ACHK;
        end
      end
      S_ACHK: begin
        if (stat.is_free) state_nxt = S_FCHK;
        else if (stat.size_bad) begin
          cmd.op    = OP_FAIL;
          cmd.code  = ST_BAD_SIZE;
          state_nxt = S_FIN;
        end else state_nxt = S_ALVL;
      end
      S_ALVL: begin
        if (stat.fits_half) cmd.op = OP_HALVE;
        else state_nxt = S_ARD;
      end
      S_ARD: begin
        cmd.op    = OP_SCAN_RD;
        state_nxt = S_ATST;
      end
      S_ATST: begin
        if (stat.scan_hit) begin
          cmd.op    = OP_TAKE;
          state_nxt = S_MCHK;
        end else if (stat.scan_last) begin
          cmd.op    = OP_FAIL;
          cmd.code  = ST_NO_FIT;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_SCAN_NEXT;
          state_nxt = S_ARD;
        end
      end
      S_MCHK: begin
        if (stat.mark_done) state_nxt = S_FIN;
        else if (stat.mark_left) state_nxt = S_MRD;
        else cmd.op = OP_MARK_SKIP;
      end
      S_MRD: begin
        cmd.op    = OP_MARK_RD;
        state_nxt = S_MWR;
      end
      S_MWR: begin
        cmd.op    = OP_MARK_WR;
        state_nxt = S_MCHK;
      end
      S_FCHK: begin
        if (stat.addr_ok) begin
          cmd.op    = OP_FREE_IDX;
          state_nxt = S_FRD;
        end else begin
          cmd.op    = OP_FAIL;
          cmd.code  = ST_BAD_ADDR;
          state_nxt = S_FIN;
        end
      end
      S_FRD: begin
        cmd.op    = OP_FREE_RD;
        state_nxt = S_FTST;
      end
      S_FTST: begin
        if (stat.entry_zero) begin
          cmd.op    = OP_FAIL;
          cmd.code  = ST_BAD_ADDR;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_FREE_CLR;
          state_nxt = S_GCHK;
        end
      end
      S_GCHK: begin
        if (stat.merge_ok) state_nxt = S_GRD;
        else state_nxt = S_FIN;
      end
      S_GRD: begin
        cmd.op    = OP_MERGE_RD;
        state_nxt = S_GTST;
      end
      S_GTST: begin
        if (stat.buddy_eq) state_nxt = S_GW1;
        else state_nxt = S_FIN;
      end
      S_GW1: begin
        cmd.op    = OP_MERGE_W1;
        state_nxt = S_GW2;
      end
      S_GW2: begin
        cmd.op    = OP_MERGE_W2;
        state_nxt = S_GCHK;
      end
      S_FIN: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // checks
  `BBA_ASSERT(a_accept_leaves_idle, clk, rst_n,
              (in_valid && in_ready) |=> (state_r != S_IDLE))
  `BBA_NEVER(a_no_accept_in_clear, clk, rst_n, (state_r == S_CLR) && in_ready)
  `BBA_ASSERT(a_fin_waits_stall, clk, rst_n,
              (state_r == S_FIN && out_valid_r && !out_ready) |=> (state_r == S_FIN))
  `BBA_ASSERT(a_publish_sets_valid, clk, rst_n,
              (cmd.op == OP_PUBLISH) |=> out_valid_r)

endmodule
`default_nettype wire

>>> bench/testbench.sv
// Testbench of buddy_block_allocator_unit: random and directed allocate/free beats
// checked against an in-bench model of the buddy block table.
// Depends on bba_pkg and the bba_req_if, bba_rsp_if and bba_cfg_if interfaces.
`timescale 1ns / 100ps
module testbench import bba_pkg::*; ;

  localparam int unsigned HEAP  = 16384;
  localparam int unsigned UNIT  = 32;
  localparam int unsigned NUNIT = HEAP / UNIT;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [STAT_W-1:0] status;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bba_req_if req_bus();
  bba_rsp_if rsp_bus();
  bba_cfg_if cfg_bus();

  buddy_block_allocator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_bus(req_bus.sink), .out_bus(rsp_bus.source), .cfg_bus(cfg_bus.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [14:0] table_q [NUNIT];
  logic [31:0] base_q;
  logic [31:0] live_blocks [$];

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  logic [31:0] pending_base;
  logic        base_write_req = 1'b0;
  int errors = 0;
  int shown = 0;
  int idle_cycles = 0;

  function automatic bit alloc_walk(input int unsigned size, input int unsigned first,
                                    input int unsigned count, output int unsigned unit);
    int unsigned half;
    int unsigned mid;
    half = count / 2;
    mid = first + half;
    if (size <= half * UNIT) begin
      if (alloc_walk(size, first, half, unit)) begin
        if (!table_q[mid][0]) table_q[mid] = 15'(half * UNIT);
        return 1'b1;
      end
      return alloc_walk(size, mid, count - half, unit);
    end
    if (!table_q[first][0] && table_q[first] >= count * UNIT) begin
      table_q[first] = 15'(count * UNIT) | 15'd1;
      unit = first;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void merge_up(input int unsigned idx);
    int unsigned bytes;
    int unsigned units;
    int unsigned buddy;
    forever begin
      bytes = table_q[idx];
      units = bytes / UNIT;
      if (bytes >= HEAP || units == 0) return;
      if (((idx / units) & 1) == 0) begin
        buddy = idx + units;
        if (buddy >= NUNIT || table_q[buddy] != bytes) return;
        table_q[buddy] = '0;
        table_q[idx] = 15'(bytes * 2);
      end else begin
        if (units > idx) return;
        buddy = idx - units;
        if (table_q[buddy] != bytes) return;
        table_q[idx] = '0;
        table_q[buddy] = 15'(bytes * 2);
        idx = buddy;
      end
    end
  endfunction

  function automatic rsp_t predict_block(input req_t r);
    rsp_t o;
    int unsigned unit;
    logic [31:0] off;
    int unsigned idx;
    o = '0;
    if (r.mode == MODE_ALLOC) begin
      if (r.size < UNIT || r.size > HEAP) o.status = ST_BAD_SIZE;
      else if (alloc_walk(r.size, 0, NUNIT, unit)) begin
        o.addr = base_q + unit * UNIT;
        o.status = ST_OK;
      end else o.status = ST_NO_FIT;
    end else begin
      off = r.addr - base_q;
      if (r.addr < base_q || off > HEAP - UNIT) o.status = ST_BAD_ADDR;
      else begin
        idx = off / UNIT;
        if ((table_q[idx] & ~15'd1) == 0) o.status = ST_BAD_ADDR;
        else begin
          table_q[idx] = table_q[idx] & ~15'd1;
          merge_up(idx);
          o.addr = r.addr;
          o.status = ST_OK;
        end
      end
    end
    return o;
  endfunction

  // Driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
      cfg_bus.valid <= 1'b0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        base_q = cfg_bus.data;
        cfg_bus.valid <= 1'b0;
      end else if (base_write_req && !cfg_bus.valid) begin
        cfg_bus.data <= pending_base;
        cfg_bus.valid <= 1'b1;
        base_write_req = 1'b0;
      end
      if (req_bus.valid && req_bus.ready) begin
        expected_rsps.push_back(predict_block(pending_reqs.pop_front()));
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_bus.valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !base_write_req && !cfg_bus.valid) begin
          req_bus.valid <= 1'b1;
          req_bus.mode <= pending_reqs[0].mode;
          req_bus.request_size <= pending_reqs[0].size;
          req_bus.address <= pending_reqs[0].addr;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end
        end else req_bus.valid <= 1'b0;
      end
    end
  end

  // Monitor with receiver stall pattern
  logic [7:0] stall_pat;
  int phase = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
      stall_pat <= 8'hff;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_rsps.size() == 0) begin
          errors++;
          if (shown < 10) begin
            shown++;
            $display("unexpected beat: addr %h status %0d", rsp_bus.block_address,
                     rsp_bus.status);
          end
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (e.addr !== rsp_bus.block_address || e.status !== rsp_bus.status) begin
            errors++;
            if (shown < 10) begin
              shown++;
              $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                       e.addr, e.status, rsp_bus.block_address, rsp_bus.status);
            end
          end
        end
      end
      phase = (phase + 1) % 8;
      if (phase == 0) stall_pat <= ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
      rsp_bus.ready <= stall_pat[phase];
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready) || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic req_t alloc_req(input int unsigned size);
    req_t r;
    r.mode = MODE_ALLOC;
    r.size = 16'(size);
    r.addr = $urandom;
    return r;
  endfunction

  function automatic req_t free_req(input logic [31:0] a);
    req_t r;
    r.mode = MODE_FREE;
    r.size = 16'($urandom);
    r.addr = a;
    return r;
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_base(input logic [31:0] b);
    pending_base = b;
    base_write_req = 1'b1;
    while (base_write_req || cfg_bus.valid) @(posedge clk);
  endtask

  // Random mix: mostly sensible allocate/free pairs, some noise
  task automatic random_phase(input int n, input logic [31:0] b);
    int k;
    int unsigned sz;
    logic [31:0] a;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          sz = ($urandom_range(0, 4) == 0) ? $urandom_range(32, HEAP)
                                           : $urandom_range(32, 1024);
          pending_reqs.push_back(alloc_req(sz));
          live_blocks.push_back(b + UNIT * $urandom_range(0, NUNIT - 1));
        end
        4, 5, 6: begin
          a = (live_blocks.size() > 0) ? live_blocks[$urandom_range(0, live_blocks.size()-1)]
                                       : b;
          pending_reqs.push_back(free_req(a));
        end
        7: pending_reqs.push_back(free_req(b + $urandom_range(0, HEAP)));
        8: pending_reqs.push_back(free_req($urandom));
        default: pending_reqs.push_back(alloc_req($urandom));
      endcase
    end
    drain();
  endtask

  initial begin
    logic [31:0] b;
    int k;
    int unsigned a_k;
    req_bus.valid = 1'b0;
    req_bus.mode = '0;
    req_bus.request_size = '0;
    req_bus.address = '0;
    rsp_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    base_q = BASE_AT_RESET;
    for (k = 0; k < NUNIT; k++) table_q[k] = '0;
    table_q[0] = 15'(HEAP);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: size bounds, full heap, bad addresses, double free, unaligned
    b = BASE_AT_RESET;
    pending_reqs.push_back(alloc_req(0));
    pending_reqs.push_back(alloc_req(31));
    pending_reqs.push_back(alloc_req(HEAP + 1));
    pending_reqs.push_back(alloc_req(16'hffff));
    pending_reqs.push_back(alloc_req(HEAP));
    pending_reqs.push_back(alloc_req(32));
    pending_reqs.push_back(free_req(b));
    pending_reqs.push_back(free_req(b));
    pending_reqs.push_back(alloc_req(32));
    pending_reqs.push_back(alloc_req(33));
    pending_reqs.push_back(alloc_req(64));
    pending_reqs.push_back(free_req(b + 32));
    pending_reqs.push_back(free_req(b + 64 + 5));
    pending_reqs.push_back(free_req(b + 96));
    pending_reqs.push_back(free_req(b - 1));
    pending_reqs.push_back(free_req(b + HEAP - UNIT + 31));
    pending_reqs.push_back(free_req(b + HEAP));
    pending_reqs.push_back(free_req(32'hffff_ffff));
    pending_reqs.push_back(free_req(32'h0));
    pending_reqs.push_back(free_req(b));
    drain();

    // Phases over several bases, extremes included
    for (k = 0; k < 5; k++) begin
      case (k)
        0: b = 32'h0000_0000;
        1: b = 32'hffff_c000;
        2: b = 32'hffff_f000;
        3: b = $urandom;
        default: b = BASE_AT_RESET;
      endcase
      set_base(b);
      live_blocks.delete();
      for (a_k = 0; a_k < 4; a_k++) live_blocks.push_back(b + a_k * 1024);
      random_phase(200, b);
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/bba_pkg.sv
rtl/bba_req_if.sv
rtl/bba_rsp_if.sv
rtl/bba_cfg_if.sv
rtl/bba_datapath.sv
rtl/bba_ctrl.sv
rtl/buddy_block_allocator_unit.sv
bench/testbench.sv
